/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/vas_pkg.sv */
// types and constants of the valve actuation supervisor
package vas_pkg;

  // reaction counter width and the width used for timeout and settle compares
  localparam int unsigned CounterBits = 16;
  localparam int unsigned TimeBits    = 16;
  localparam int unsigned CmpBits     = (CounterBits > TimeBits) ? CounterBits : TimeBits;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  // fault flag bit positions
  localparam int unsigned FltNoOpen  = 0;
  localparam int unsigned FltNoClose = 1;
  localparam int unsigned FltUndef   = 2;
  localparam int unsigned FltAmbig   = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_EVAL  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COMMAND = 2'd1,
    PH_AWAIT   = 2'd2,
    PH_SETTLE  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_VALVE_TYPE    = 3'd0,
    CFG_OPEN_TIMEOUT  = 3'd1,
    CFG_CLOSE_TIMEOUT = 3'd2,
    CFG_OPEN_SETTLE   = 3'd3,
    CFG_CLOSE_SETTLE  = 3'd4,
    CFG_NORM_OPEN     = 3'd5,
    CFG_NORM_CLOSE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] op;
    logic       action;
    logic       open_feedback;
    logic       close_feedback;
  } in_word_t;

  typedef struct packed {
    logic       drive_primary;
    logic       drive_secondary;
    phase_e     phase;
    logic       fault_no_open;
    logic       fault_no_close;
    logic       fault_undefined;
    logic       fault_ambiguous;
    logic       done_res;
    logic [7:0] norm_code;
  } out_word_t;

endpackage

/* rtl/valve_actuation_supervisor_top.sv */
// Valve actuation supervisor: one input word in, one status word out.
// The result word of an accepted input word is registered and appears in the next cycle.
// Throughput: one word per cycle; the output register stalls input only when
// its word is held by the consumer.
// Reset: async active low; idle phase, counter, drives and faults cleared,
// configuration registers back to their default values.
module valve_actuation_supervisor_top
  import vas_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_word_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_word_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  // configuration registers
  logic [1:0]          valve_type_q;
  logic [TimeBits-1:0] open_timeout_q, close_timeout_q;
  logic [TimeBits-1:0] open_settle_q, close_settle_q;
  logic [7:0]          norm_open_q, norm_close_q;

  // supervisor state
  phase_e                 phase_q, phase_d;
  logic [CounterBits-1:0] cnt_q, cnt_d;
  logic                   drive_a_q, drive_a_d;
  logic                   drive_b_q, drive_b_d;
  logic [3:0]             flt_q, flt_d;

  // result register
  logic      out_valid_q;
  out_word_t out_data_q, out_data_d;

  logic in_acc;
  logic done;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_type_q    <= 2'd1;
      open_timeout_q  <= TimeBits'(2);
      close_timeout_q <= TimeBits'(2);
      open_settle_q   <= TimeBits'(2);
      close_settle_q  <= TimeBits'(2);
      norm_open_q     <= 8'd36;
      norm_close_q    <= 8'd37;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_VALVE_TYPE:    valve_type_q    <= cfg_data_i[1:0];
        CFG_OPEN_TIMEOUT:  open_timeout_q  <= cfg_data_i[TimeBits-1:0];
        CFG_CLOSE_TIMEOUT: close_timeout_q <= cfg_data_i[TimeBits-1:0];
        CFG_OPEN_SETTLE:   open_settle_q   <= cfg_data_i[TimeBits-1:0];
        CFG_CLOSE_SETTLE:  close_settle_q  <= cfg_data_i[TimeBits-1:0];
        CFG_NORM_OPEN:     norm_open_q     <= cfg_data_i[7:0];
        CFG_NORM_CLOSE:    norm_close_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // per-word decode
  logic               two_in, two_out, act, fo, fc, match;
  logic [3:0]         dir_fault;
  logic [CmpBits-1:0] cnt_ext, timeout_ext, settle_ext;
  logic [7:0]         norm;

  always_comb begin
    two_in      = valve_type_q[0];
    two_out     = valve_type_q[1];
    act         = in_data_i.action;
    fo          = in_data_i.open_feedback;
    fc          = in_data_i.close_feedback;
    match       = two_in ? ((fo == act) && (fc != act)) : (fo == act);
    dir_fault   = act ? (4'b1 << FltNoOpen) : (4'b1 << FltNoClose);
    cnt_ext     = CmpBits'(cnt_q);
    timeout_ext = CmpBits'(act ? open_timeout_q : close_timeout_q);
    settle_ext  = CmpBits'(act ? open_settle_q : close_settle_q);
    norm        = act ? norm_open_q : norm_close_q;
  end

  // next state of the supervisor
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    drive_a_d = drive_a_q;
    drive_b_d = drive_b_q;
    flt_d     = flt_q;
    done      = 1'b0;
    case (in_data_i.op)
      OP_TICK: begin
        if (cnt_q != {CounterBits{1'b1}}) cnt_d = cnt_q + CounterBits'(1);
      end
      OP_START: begin
        phase_d = PH_COMMAND;
      end
      OP_EVAL: begin
        case (phase_q)
          PH_COMMAND: begin
            drive_a_d = act;
            drive_b_d = two_out & ~act;
            if (match) begin
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              cnt_d   = '0;
              phase_d = PH_AWAIT;
            end
          end
          PH_AWAIT: begin
            if (two_in) begin
              flt_d = flt_q & ~(dir_fault | (4'b1 << FltUndef) | (4'b1 << FltAmbig));
            end
            if (match) begin
              if (!two_in) flt_d = flt_q & ~dir_fault;
              cnt_d   = '0;
              phase_d = PH_SETTLE;
            end else if (cnt_ext > timeout_ext) begin
              if (two_in && !fo && !fc)    flt_d[FltUndef] = 1'b1;
              else if (two_in && fo && fc) flt_d[FltAmbig] = 1'b1;
              else                         flt_d = flt_d | dir_fault;
            end
          end
          PH_SETTLE: begin
            if (cnt_ext >= settle_ext) begin
              done    = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result word from the updated state
  always_comb begin
    out_data_d.drive_primary   = drive_a_d;
    out_data_d.drive_secondary = drive_b_d;
    out_data_d.phase           = phase_d;
    out_data_d.fault_no_open   = flt_d[FltNoOpen];
    out_data_d.fault_no_close  = flt_d[FltNoClose];
    out_data_d.fault_undefined = flt_d[FltUndef];
    out_data_d.fault_ambiguous = flt_d[FltAmbig];
    out_data_d.done_res        = done;
    out_data_d.norm_code       = done ? norm : 8'd0;
  end

  // state update on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      drive_a_q <= 1'b0;
      drive_b_q <= 1'b0;
      flt_q     <= '0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      drive_a_q <= drive_a_d;
      drive_b_q <= drive_b_d;
      flt_q     <= flt_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/vas_checker.sv */
// port-level checker for the valve actuation supervisor, bound to the top level
`include "assert_macros.svh"

module vas_checker
  import vas_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // a stalled result word stays valid
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // every accepted input word yields a result word next cycle
  `ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o)

  // a finished sequence returns to idle, otherwise the norm code is zero
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni,
               out_valid_o && out_data_o.done_res, out_data_o.phase == PH_IDLE)
  `ASSERT_IMPL(a_code_zero, clk_i, rst_ni,
               out_valid_o && !out_data_o.done_res, out_data_o.norm_code == 8'd0)

  // the two drives never energize together
  `ASSERT_IMPL(a_drive_excl, clk_i, rst_ni, out_valid_o,
               !(out_data_o.drive_primary && out_data_o.drive_secondary))

endmodule

bind valve_actuation_supervisor_top vas_checker u_vas_checker (.*);
